### rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and helpers for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Field widths
  localparam int unsigned HueW   = 16;
  localparam int unsigned LevelW = 8;
  localparam int unsigned FracW  = 16;
  localparam int unsigned ScaleW = HueW + 3;   // 6 * hue
  localparam int unsigned NumW   = 24;         // 255 * 2^16 fits in 24 bits
  localparam int unsigned ProdW  = NumW + LevelW;

  // Full scale of a level and of the product denominator (255 * 65536)
  localparam logic [LevelW-1:0] LevelMax = 8'd255;
  localparam logic [NumW-1:0]   NumOne   = 24'd16711680;
  localparam logic [FracW:0]    FracOne  = 17'h10000;

  // Hue sector: which of red/green/blue carries V, p, q and t
  typedef enum logic [2:0] {
    SEC_RED_RISE_G  = 3'd0,
    SEC_GRN_FALL_R  = 3'd1,
    SEC_GRN_RISE_B  = 3'd2,
    SEC_BLU_FALL_G  = 3'd3,
    SEC_BLU_RISE_R  = 3'd4,
    SEC_RED_FALL_B  = 3'd5
  } sector_e;

  typedef logic [LevelW-1:0] level_t;

  // floor(x / 255) for x <= 65025, no divider
  function automatic level_t div255(input logic [15:0] x);
    logic [16:0] x1;
    logic [16:0] s;
    x1 = {1'b0, x} + 17'd1;
    s  = x1 + (x1 >> 8);
    return s[15:8];
  endfunction

endpackage

### rtl/hsv_to_rgb_converter_top.sv
// An accepted input word passes through four register stages; the accepting
// edge loads the first one, and the output word is valid once the word
// reaches the fourth.
// Throughput: one pixel per clock while the output is not stalled; the four
// stages advance independently, so a stalled output only holds the stages
// behind it once they fill up. Reset (rst_ni low, asynchronous) empties
// every stage; data registers are not cleared.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// Streaming HSV to RGB converter: sector split, p/q/t scaling, channel mux.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top
  import hsv2rgb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] hue_turn, [23:16] sat_level, [31:24] value_level, [39:32] alpha_in
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [31:24] alpha_out
  output logic [31:0] m_axis_tdata
);

  // Per-stage valid bits and load enables
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  assign s4_rdy = !s4_v_q || m_axis_tready;
  assign s3_rdy = !s3_v_q || s4_rdy;
  assign s2_rdy = !s2_v_q || s3_rdy;
  assign s1_rdy = !s1_v_q || s2_rdy;
  assign s_axis_tready = s1_rdy;

  // Input unpack
  logic [HueW-1:0] hue_in;
  level_t          sat_in, val_in, alpha_in;
  assign hue_in   = s_axis_tdata[15:0];
  assign sat_in   = s_axis_tdata[23:16];
  assign val_in   = s_axis_tdata[31:24];
  assign alpha_in = s_axis_tdata[39:32];

  // Stage 1: 6 * hue
  logic [ScaleW-1:0] s1_scaled_q, s1_scaled_d;
  level_t            s1_sat_q, s1_val_q, s1_alpha_q;

  assign s1_scaled_d = ({3'b000, hue_in} << 2) + ({3'b000, hue_in} << 1);

  // Stage 2: numerators 255*2^16 - S*2^16, 255*2^16 - S*frac and 255*2^16 - S*(2^16 - frac) for p, q and t
  logic [NumW-1:0]  s2_np_q, s2_nq_q, s2_nt_q;
  logic [NumW-1:0]  s2_np_d, s2_nq_d, s2_nt_d;
  logic [FracW-1:0] frac;
  logic [FracW:0]   frac_t;
  logic [NumW-1:0]  sf_t;
  sector_e          s2_sec_q;
  level_t           s2_val_q, s2_alpha_q;

  assign frac    = s1_scaled_q[FracW-1:0];
  assign frac_t  = FracOne - {1'b0, frac};
  assign sf_t    = NumW'(s1_sat_q) * NumW'(frac_t);
  assign s2_np_d = {LevelMax - s1_sat_q, 16'h0000};
  assign s2_nq_d = NumOne - NumW'(s1_sat_q) * NumW'(frac);
  assign s2_nt_d = NumOne - sf_t;

  // Stage 3: V * numerator, keep the part above 2^16
  logic [15:0] s3_mp_q, s3_mq_q, s3_mt_q;
  logic [ProdW-1:0] prod_p, prod_q, prod_t;
  sector_e     s3_sec_q;
  level_t      s3_val_q, s3_alpha_q;

  assign prod_p = ProdW'(s2_val_q) * ProdW'(s2_np_q);
  assign prod_q = ProdW'(s2_val_q) * ProdW'(s2_nq_q);
  assign prod_t = ProdW'(s2_val_q) * ProdW'(s2_nt_q);

  // Stage 4: divide by 255 and route to channels
  level_t lvl_p, lvl_q, lvl_t;
  level_t red_d, green_d, blue_d;
  level_t s4_red_q, s4_green_q, s4_blue_q, s4_alpha_q;

  assign lvl_p = div255(s3_mp_q);
  assign lvl_q = div255(s3_mq_q);
  assign lvl_t = div255(s3_mt_q);

  always_comb begin
    case (s3_sec_q)
      SEC_RED_RISE_G: begin
        red_d = s3_val_q; green_d = lvl_t;    blue_d = lvl_p;
      end
      SEC_GRN_FALL_R: begin
        red_d = lvl_q;    green_d = s3_val_q; blue_d = lvl_p;
      end
      SEC_GRN_RISE_B: begin
        red_d = lvl_p;    green_d = s3_val_q; blue_d = lvl_t;
      end
      SEC_BLU_FALL_G: begin
        red_d = lvl_p;    green_d = lvl_q;    blue_d = s3_val_q;
      end
      SEC_BLU_RISE_R: begin
        red_d = lvl_t;    green_d = lvl_p;    blue_d = s3_val_q;
      end
      SEC_RED_FALL_B: begin
        red_d = s3_val_q; green_d = lvl_p;    blue_d = lvl_q;
      end
      default: begin
        red_d = s3_val_q; green_d = lvl_p;    blue_d = lvl_q;
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= s_axis_tvalid;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
      if (s4_rdy) s4_v_q <= s3_v_q;
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_scaled_q <= s1_scaled_d;
      s1_sat_q    <= sat_in;
      s1_val_q    <= val_in;
      s1_alpha_q  <= alpha_in;
    end
    if (s2_rdy) begin
      s2_np_q    <= s2_np_d;
      s2_nq_q    <= s2_nq_d;
      s2_nt_q    <= s2_nt_d;
      s2_sec_q   <= sector_e'(s1_scaled_q[ScaleW-1:FracW]);
      s2_val_q   <= s1_val_q;
      s2_alpha_q <= s1_alpha_q;
    end
    if (s3_rdy) begin
      s3_mp_q    <= prod_p[ProdW-1:16];
      s3_mq_q    <= prod_q[ProdW-1:16];
      s3_mt_q    <= prod_t[ProdW-1:16];
      s3_sec_q   <= s2_sec_q;
      s3_val_q   <= s2_val_q;
      s3_alpha_q <= s2_alpha_q;
    end
    if (s4_rdy) begin
      s4_red_q   <= red_d;
      s4_green_q <= green_d;
      s4_blue_q  <= blue_d;
      s4_alpha_q <= s3_alpha_q;
    end
  end

  assign m_axis_tvalid = s4_v_q;
  assign m_axis_tdata  = {s4_alpha_q, s4_blue_q, s4_green_q, s4_red_q};

  // Checks
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> s1_v_q)
    else $error("accepted word did not reach stage 1");

  a_full_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s2_v_q && s3_v_q && s4_v_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while pipeline full and stalled");

  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> s1_scaled_q[ScaleW-1:FracW] <= 3'd5)
    else $error("hue sector out of range");

  a_p_smallest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q |-> (s3_mp_q <= s3_mq_q) && (s3_mp_q <= s3_mt_q))
    else $error("p product exceeds q or t");

endmodule
